// ----- sv/assert_macros.svh -----
// Assertion helpers for the RTL, included by sensor_power_sequencer_top.sv.
// Each macro expands to a concurrent assertion in simulation and to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ----- sv/sps_pkg.sv -----
package sps_pkg;

    // Phase codes.
    typedef logic [2:0] t_phase;
    localparam t_phase PH_UNPOWERED = 3'd0;
    localparam t_phase PH_PREPARE   = 3'd1;
    localparam t_phase PH_WARMING   = 3'd2;
    localparam t_phase PH_BRINGUP   = 3'd3;
    localparam t_phase PH_RUNNING   = 3'd4;
    localparam t_phase PH_COOLING   = 3'd5;

    localparam int MS_W = 16;
    typedef logic [MS_W-1:0] t_ms;
    localparam t_ms MS_MAX = '1;

    // Configuration register indexes and reset values.
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PREPARE_OFF = 2'd0;
    localparam t_cfg_idx CFG_SETTLE      = 2'd1;
    localparam t_cfg_idx CFG_FILTER_WARM = 2'd2;
    localparam t_ms PREPARE_OFF_RST = 16'd500;
    localparam t_ms SETTLE_RST      = 16'd200;
    localparam t_ms FILTER_WARM_RST = 16'd1000;

    // Sequencer state carried from tick to tick.
    typedef struct packed {
        t_phase phase;
        t_ms    elapsed;
        logic   up_pending;
        logic   down_pending;
        logic   warmed;
        logic   enable;
    } t_state;

    // One tick's input item.
    typedef struct packed {
        logic link_alive;
        logic bringup_ok;
        logic power_down_req;
        logic power_up_req;
    } t_tick;

    // One result item.
    typedef struct packed {
        logic   warmed;
        logic   bringup_strobe;
        t_phase phase;
        logic   enable_level;
    } t_result;

    // Timing thresholds.
    typedef struct packed {
        t_ms prepare_off;
        t_ms settle;
        t_ms filter_warm;
    } t_cfg;

endpackage

// ----- sv/sps_step.sv -----
module sps_step (
    input  sps_pkg::t_state  i_state,
    input  sps_pkg::t_tick   i_tick,
    input  sps_pkg::t_cfg    i_cfg,
    output sps_pkg::t_state  o_state,
    output sps_pkg::t_result o_result
);
    import sps_pkg::*;

    t_ms    elapsed_inc;
    t_state s;
    logic   strobe;

    // Saturating millisecond count for this tick.
    assign elapsed_inc = (i_state.elapsed == MS_MAX) ? i_state.elapsed
                                                     : i_state.elapsed + t_ms'(1);

    // Phase transitions for one tick.
    always_comb begin
        s              = i_state;
        s.up_pending   = i_state.up_pending | i_tick.power_up_req;
        s.down_pending = i_state.down_pending | i_tick.power_down_req;
        s.elapsed      = elapsed_inc;
        strobe         = 1'b0;
        case (i_state.phase)
            PH_UNPOWERED: begin
                if (s.up_pending) begin
                    s.enable     = 1'b0;
                    s.up_pending = 1'b0;
                    s.phase      = PH_PREPARE;
                    s.elapsed    = '0;
                end
            end
            PH_PREPARE: begin
                if (elapsed_inc > i_cfg.prepare_off) begin
                    s.enable  = 1'b1;
                    s.phase   = PH_WARMING;
                    s.elapsed = '0;
                end
            end
            PH_WARMING: begin
                if (elapsed_inc > i_cfg.settle) begin
                    s.enable = 1'b1;
                    s.phase  = PH_BRINGUP;
                end
            end
            PH_BRINGUP: begin
                strobe    = 1'b1;
                s.elapsed = '0;
                if (i_tick.bringup_ok) begin
                    s.warmed = 1'b0;
                    s.phase  = PH_RUNNING;
                end else begin
                    s.enable = 1'b0;
                    s.phase  = PH_COOLING;
                end
            end
            PH_RUNNING: begin
                if (!i_tick.link_alive) begin
                    // Link lost: force a restart through unpowered.
                    s.up_pending = 1'b1;
                    s.enable     = 1'b0;
                    s.phase      = PH_UNPOWERED;
                end else if (s.down_pending) begin
                    s.enable       = 1'b0;
                    s.down_pending = 1'b0;
                    s.warmed       = 1'b0;
                    s.phase        = PH_COOLING;
                    s.elapsed      = '0;
                end else if (elapsed_inc > i_cfg.filter_warm) begin
                    s.warmed = 1'b1;
                end
            end
            PH_COOLING: begin
                if (elapsed_inc > i_cfg.settle) begin
                    s.enable = 1'b0;
                    s.phase  = PH_UNPOWERED;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_state                 = s;
    assign o_result.enable_level   = s.enable;
    assign o_result.phase          = s.phase;
    assign o_result.bringup_strobe = strobe;
    assign o_result.warmed         = s.warmed;

endmodule

// ----- sv/sensor_power_sequencer_top.sv -----
// An input transfer is captured in the input register; its result is loaded into the
// output register as soon as the result register can take a value.
// Throughput: one tick per cycle while results are taken; the sequencer state is updated
// in the same cycle the result register is loaded, so ticks follow back to back.
// Reset: synchronous, active low; clears the state, both valid flags and loads the
// default thresholds (500, 200 and 1000 ms).
`include "assert_macros.svh"

module sensor_power_sequencer_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Slave side; tdata bits from 0: power_up_req, power_down_req, bringup_ok,
    // link_alive, 4 unused bits.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,
    // Master side; tdata bits from 0: enable_level, phase[2:0], bringup_strobe,
    // warmed, 2 zero bits.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [7:0]            o_m_tdata,
    // Configuration write port.
    input  logic                  i_cfg_wr_en,
    input  sps_pkg::t_cfg_idx     i_cfg_addr,
    input  sps_pkg::t_ms          i_cfg_wdata
);
    import sps_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_tick   r_in;
    logic    r_in_vld;
    t_result r_out;
    t_result n_out;
    logic    r_out_vld;
    logic    out_free;
    logic    fire;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prepare_off <= PREPARE_OFF_RST;
            r_cfg.settle      <= SETTLE_RST;
            r_cfg.filter_warm <= FILTER_WARM_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_PREPARE_OFF: r_cfg.prepare_off <= i_cfg_wdata;
                CFG_SETTLE:      r_cfg.settle      <= i_cfg_wdata;
                CFG_FILTER_WARM: r_cfg.filter_warm <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Handshake: the input register drains whenever the result register can take a value.
    assign out_free   = !r_out_vld || i_m_tready;
    assign fire       = r_in_vld && out_free;
    assign o_s_tready = !r_in_vld || out_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in <= t_tick'(i_s_tdata[3:0]);
        end
    end

    // Next-state logic for one tick.
    sps_step u_step (
        .i_state  (r_state),
        .i_tick   (r_in),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Sequencer state advances once per processed tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_UNPOWERED, elapsed: '0, up_pending: 1'b0,
                         down_pending: 1'b0, warmed: 1'b0, enable: 1'b0};
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {2'b00, r_out};

    // The enable drive is high exactly in the powered phases.
    `ASSERT_ALWAYS(a_enable_phase, i_clk, i_rst_n, r_state.enable == (r_state.phase == PH_WARMING || r_state.phase == PH_BRINGUP || r_state.phase == PH_RUNNING), "enable does not match phase")
    // A bring-up tick always leaves the bring-up phase.
    `ASSERT_IMPL(a_strobe_exit, i_clk, i_rst_n, r_out_vld && r_out.bringup_strobe |-> r_out.phase == PH_RUNNING || r_out.phase == PH_COOLING, "bring-up strobe without phase exit")
    // A processed tick always lands in the result register.
    `ASSERT_IMPL(a_fire_result, i_clk, i_rst_n, fire |=> r_out_vld, "processed tick lost")
    // The phase only moves when a tick is processed.
    `ASSERT_IMPL(a_phase_hold, i_clk, i_rst_n, !fire |=> $stable(r_state.phase), "phase changed without a tick")

endmodule

// ----- bench/tb_sensor_power_sequencer_top.sv -----
`timescale 1ns / 1ps

module tb_sensor_power_sequencer_top;
    import sps_pkg::*;

    // Index past the last threshold register; the block ignores writes to it.
    localparam t_cfg_idx CFG_UNUSED = 2'd3;

    localparam int  DRAIN_CYCLES   = 8;
    localparam int  CYCLE_LIMIT    = 1_000_000;
    localparam int  RANDOM_PHASES  = 6;
    localparam int  TICKS_PER_PHASE = 100;
    localparam int  LONG_HOLD_TICKS = 100;
    localparam int  MAX_REPORTS    = 100;

    // Directed ticks, bits from the top: link_alive, bringup_ok, power_down_req,
    // power_up_req. All thresholds are zero while these run.
    localparam logic [3:0] DIRECTED [0:24] = '{
        4'b0000,  // unpowered with nothing pending
        4'b0001,  // power-up request enters prepare
        4'b0000,  // prepare to warming
        4'b0000,  // warming to bring-up
        4'b1000,  // bring-up failure, go cooling
        4'b0000,  // cooling to unpowered
        4'b0011,  // both requests; power-down stays pending
        4'b0000,
        4'b0000,
        4'b0100,  // bring-up succeeds, running
        4'b1000,  // pending power-down consumed while running
        4'b0000,
        4'b0001,
        4'b0000,
        4'b0000,
        4'b0100,
        4'b1000,  // filter warm-up reached
        4'b1100,
        4'b0000,  // link failure forces a restart, warmed kept
        4'b0000,
        4'b0000,
        4'b0000,
        4'b0100,
        4'b1111,  // every request bit at once while running
        4'b0000
    };

    // Scoreboard: mirrors the sequencer state and holds predicted status words.
    class sequencer_scoreboard;
        t_cfg    thresholds;
        t_phase  cur_phase;
        t_ms     elapsed;
        logic    up_pend;
        logic    down_pend;
        logic    warmed;
        logic    enabled;
        t_result predicted_status[$];
        int      mismatch_count;
        int      status_count;

        function new();
            thresholds.prepare_off = PREPARE_OFF_RST;
            thresholds.settle      = SETTLE_RST;
            thresholds.filter_warm = FILTER_WARM_RST;
            cur_phase      = PH_UNPOWERED;
            elapsed        = '0;
            up_pend        = 1'b0;
            down_pend      = 1'b0;
            warmed         = 1'b0;
            enabled        = 1'b0;
            mismatch_count = 0;
            status_count   = 0;
        endfunction

        function void set_threshold(t_cfg_idx idx, t_ms value);
            case (idx)
                CFG_PREPARE_OFF: thresholds.prepare_off = value;
                CFG_SETTLE:      thresholds.settle      = value;
                CFG_FILTER_WARM: thresholds.filter_warm = value;
                default: ;
            endcase
        endfunction

        function int outstanding();
            return predicted_status.size();
        endfunction

        // Advance the mirrored sequencer by one accepted tick.
        function void predict_tick(t_tick t);
            t_result r;
            logic    strobe;
            strobe = 1'b0;
            if (t.power_up_req)   up_pend   = 1'b1;
            if (t.power_down_req) down_pend = 1'b1;
            if (elapsed != MS_MAX) elapsed = elapsed + 1'b1;

            case (cur_phase)
                PH_UNPOWERED: begin
                    if (up_pend) begin
                        enabled   = 1'b0;
                        up_pend   = 1'b0;
                        cur_phase = PH_PREPARE;
                        elapsed   = '0;
                    end
                end
                PH_PREPARE: begin
                    if (elapsed > thresholds.prepare_off) begin
                        enabled   = 1'b1;
                        cur_phase = PH_WARMING;
                        elapsed   = '0;
                    end
                end
                PH_WARMING: begin
                    // Bring-up does not restart the timer.
                    if (elapsed > thresholds.settle) begin
                        enabled   = 1'b1;
                        cur_phase = PH_BRINGUP;
                    end
                end
                PH_BRINGUP: begin
                    strobe = 1'b1;
                    if (t.bringup_ok) begin
                        warmed    = 1'b0;
                        cur_phase = PH_RUNNING;
                    end else begin
                        enabled   = 1'b0;
                        cur_phase = PH_COOLING;
                    end
                    elapsed = '0;
                end
                PH_RUNNING: begin
                    if (!t.link_alive) begin
                        up_pend   = 1'b1;
                        enabled   = 1'b0;
                        cur_phase = PH_UNPOWERED;
                    end else if (down_pend) begin
                        enabled   = 1'b0;
                        down_pend = 1'b0;
                        warmed    = 1'b0;
                        cur_phase = PH_COOLING;
                        elapsed   = '0;
                    end else if (elapsed > thresholds.filter_warm) begin
                        warmed = 1'b1;
                    end
                end
                PH_COOLING: begin
                    if (elapsed > thresholds.settle) begin
                        enabled   = 1'b0;
                        cur_phase = PH_UNPOWERED;
                    end
                end
                default: ;
            endcase

            r.enable_level   = enabled;
            r.phase          = cur_phase;
            r.bringup_strobe = strobe;
            r.warmed         = warmed;
            predicted_status.push_back(r);
        endfunction

        task report(string what);
            if (mismatch_count < MAX_REPORTS)
                $display("[%0t] status word %0d: %s", $time, status_count, what);
            mismatch_count++;
        endtask

        // Compare one accepted status word with the oldest prediction.
        task compare_status(logic [7:0] word);
            t_result got;
            t_result want;
            got = t_result'(word[5:0]);
            if (word[7:6] != 2'b00)
                report($sformatf("padding bits are %0b", word[7:6]));
            if (predicted_status.size() == 0) begin
                report("status word arrived with no tick outstanding");
            end else begin
                want = predicted_status.pop_front();
                if (got.enable_level !== want.enable_level)
                    report($sformatf("enable_level %0b, predicted %0b",
                                     got.enable_level, want.enable_level));
                if (got.phase !== want.phase)
                    report($sformatf("phase %0d, predicted %0d", got.phase, want.phase));
                if (got.bringup_strobe !== want.bringup_strobe)
                    report($sformatf("bringup_strobe %0b, predicted %0b",
                                     got.bringup_strobe, want.bringup_strobe));
                if (got.warmed !== want.warmed)
                    report($sformatf("warmed %0b, predicted %0b", got.warmed, want.warmed));
            end
            status_count++;
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;
    logic       i_cfg_wr_en;
    t_cfg_idx   i_cfg_addr;
    t_ms        i_cfg_wdata;

    sequencer_scoreboard sb;
    bit  gaps_on;
    bit  stalls_on;
    int  stall_left;
    longint cycle_count;

    sensor_power_sequencer_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 8 ns clock.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int pick_idle_len();
        if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 70) return 0;
        return pick_idle_len();
    endfunction

    // Thresholds are mostly tiny so the sequencer cycles through every phase.
    function automatic t_ms pick_threshold();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return MS_MAX - 1'b1;
        if (r < 14) return t_ms'($urandom_range(0, 4));
        return t_ms'($urandom_range(5, 30));
    endfunction

    // Plausible traffic with occasional fully random request bits.
    function automatic t_tick pick_tick();
        t_tick t;
        if ($urandom_range(0, 9) == 0) begin
            t = t_tick'($urandom_range(0, 15));
        end else begin
            t.power_up_req   = ($urandom_range(0, 7) == 0);
            t.power_down_req = ($urandom_range(0, 14) == 0);
            t.bringup_ok     = ($urandom_range(0, 6) != 0);
            t.link_alive     = ($urandom_range(0, 19) != 0);
        end
        return t;
    endfunction

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else if (stalls_on && $urandom_range(0, 9) == 0) begin
            i_m_tready <= 1'b0;
            stall_left = pick_idle_len() - 1;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Status monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.compare_status(o_m_tdata);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // One tick transfer, preceded by a random, possibly empty, idle gap.
    task automatic send_tick(t_tick t);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0000, t};
        @(posedge i_clk);
        while (o_s_tready !== 1'b1) @(posedge i_clk);
        sb.predict_tick(t);
    endtask

    // Stop sending and wait until every predicted status word has been seen.
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(t_cfg_idx idx, t_ms value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_threshold(idx, value);
    endtask

    task automatic write_all(t_ms prep, t_ms settle, t_ms warm);
        write_threshold(CFG_PREPARE_OFF, prep);
        write_threshold(CFG_SETTLE, settle);
        write_threshold(CFG_FILTER_WARM, warm);
    endtask

    initial begin
        t_tick t;
        sb          = new();
        cycle_count = 0;
        stall_left  = 0;
        gaps_on     = 1'b0;
        stalls_on   = 1'b0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_m_tready  = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_addr  = CFG_PREPARE_OFF;
        i_cfg_wdata = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk through every phase with all thresholds at zero.
        write_all('0, '0, '0);
        write_threshold(CFG_UNUSED, MS_MAX);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        foreach (DIRECTED[i])
            send_tick(t_tick'(DIRECTED[i]));
        drain();

        // Prepare and filter warm-up thresholds at MS_MAX - 1: the prepare phase never times
        // out within this stretch, so the phase holds while the timer keeps counting.
        write_all(MS_MAX - 1'b1, '0, MS_MAX - 1'b1);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        t = t_tick'(4'b1101);
        send_tick(t);
        t.power_up_req = 1'b0;
        repeat (LONG_HOLD_TICKS - 1) send_tick(t);
        drain();

        // Random phases with fresh thresholds; one phase runs without idling.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_all(pick_threshold(), pick_threshold(), pick_threshold());
            gaps_on   = (p != 2);
            stalls_on = (p != 2);
            repeat (TICKS_PER_PHASE) send_tick(pick_tick());
            drain();
        end

        if (sb.mismatch_count == 0 && sb.outstanding() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sensor_power_sequencer_top.f -----
+incdir+sv
sv/sps_pkg.sv
sv/sps_step.sv
sv/sensor_power_sequencer_top.sv
bench/tb_sensor_power_sequencer_top.sv
